/* hdl/base64_stream_codec_macros.svh */
// Assertion macros used by the checker file of the base64 stream codec.
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64SC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64SC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/b64sc_pkg.sv */
package b64sc_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    // One unit of work for the back end: a whole or partial group and how to emit it.
    typedef struct packed {
        logic        dec;
        logic        marker;
        logic        last;
        logic [1:0]  npad;
        logic [2:0]  nres;
        logic [23:0] group;
    } cmd_t;

    function automatic logic [7:0] to_char(input logic [5:0] v);
        logic [7:0] r;
        begin
            if (v < 6'd26)
            begin
                r = 8'h41 + {2'b00, v};
            end
            else if (v < 6'd52)
            begin
                r = 8'h61 + {2'b00, v - 6'd26};
            end
            else if (v < 6'd62)
            begin
                r = 8'h30 + {2'b00, v - 6'd52};
            end
            else if (v == 6'd62)
            begin
                r = PLUS_CHAR;
            end
            else
            begin
                r = SLASH_CHAR;
            end
            return r;
        end
    endfunction

    // Bit 6 of the result flags a character outside the alphabet.
    function automatic logic [6:0] from_char(input logic [7:0] c);
        logic [6:0] r;
        begin
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                r = 7'(c - 8'h41);
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                r = 7'(c - 8'h61 + 8'd26);
            end
            else if (c >= 8'h30 && c <= 8'h39)
            begin
                r = 7'(c - 8'h30 + 8'd52);
            end
            else if (c == PLUS_CHAR)
            begin
                r = 7'd62;
            end
            else if (c == SLASH_CHAR)
            begin
                r = 7'd63;
            end
            else
            begin
                r = 7'd64;
            end
            return r;
        end
    endfunction

endpackage

/* hdl/b64sc_front.sv */
module b64sc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              cmd_push,
    output b64sc_pkg::cmd_t   cmd
);
    import b64sc_pkg::*;

    logic        mode_reg;
    logic [23:0] buf_reg, buf_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        stop_reg, stop_next;
    logic [23:0] nb_enc, nb_dec, tail_buf;
    logic [1:0]  tail_cnt;
    logic [6:0]  fc;
    logic        produce;

    assign nb_enc = {buf_reg[15:0], in_byte};
    assign fc     = from_char(in_byte);
    assign nb_dec = {buf_reg[17:0], fc[5:0]};

    always_comb
    begin
        cmd       = '0;
        produce   = 1'b0;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        stop_next = stop_reg;
        tail_buf  = buf_reg;
        tail_cnt  = cnt_reg;
        if (mode_reg == MODE_ENCODE)
        begin
            cmd.nres = 3'd4;
            if (cnt_reg == 2'd2)
            begin
                produce   = 1'b1;
                cmd.group = nb_enc;
                cmd.last  = in_last;
                buf_next  = '0;
                cnt_next  = '0;
            end
            else if (in_last)
            begin
                produce  = 1'b1;
                cmd.last = 1'b1;
                if (cnt_reg == 2'd1)
                begin
                    cmd.group = {nb_enc[15:0], 8'h00};
                    cmd.npad  = 2'd1;
                end
                else
                begin
                    cmd.group = {nb_enc[7:0], 16'h0000};
                    cmd.npad  = 2'd2;
                end
            end
            else
            begin
                buf_next = nb_enc;
                cnt_next = cnt_reg + 2'd1;
            end
        end
        else
        begin
            cmd.dec = 1'b1;
            if (!stop_reg)
            begin
                if (fc[6])
                begin
                    stop_next = 1'b1;
                end
                else if (cnt_reg == 2'd3)
                begin
                    produce   = 1'b1;
                    cmd.group = nb_dec;
                    cmd.nres  = 3'd3;
                    cmd.last  = in_last;
                    buf_next  = '0;
                    cnt_next  = '0;
                    tail_cnt  = '0;
                end
                else
                begin
                    buf_next = nb_dec;
                    cnt_next = cnt_reg + 2'd1;
                    tail_buf = nb_dec;
                    tail_cnt = cnt_reg + 2'd1;
                end
            end
            if (in_last && !produce)
            begin
                produce  = 1'b1;
                cmd.last = 1'b1;
                cmd.nres = 3'd1;
                if (tail_cnt == 2'd2)
                begin
                    cmd.group = {tail_buf[11:0], 12'h000};
                end
                else if (tail_cnt == 2'd3)
                begin
                    cmd.group = {tail_buf[17:0], 6'h00};
                    cmd.nres  = 3'd2;
                end
                else
                begin
                    cmd.marker = 1'b1;
                end
            end
        end
        if (in_last)
        begin
            buf_next  = '0;
            cnt_next  = '0;
            stop_next = 1'b0;
        end
    end

    assign cmd_push = in_valid && produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENCODE;
            buf_reg  <= '0;
            cnt_reg  <= '0;
            stop_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
            buf_reg  <= '0;
            cnt_reg  <= '0;
            stop_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            stop_reg <= stop_next;
        end
    end

endmodule

/* hdl/b64sc_cmd_fifo.sv */
module b64sc_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64sc_pkg::cmd_t   push_cmd,
    output logic              full,
    output logic              head_valid,
    output b64sc_pkg::cmd_t   head_cmd,
    input  logic              pop
);
    import b64sc_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       entry_reg [DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'(DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* hdl/b64sc_back.sv */
module b64sc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  b64sc_pkg::cmd_t   cmd,
    output logic              cmd_pop,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic              has_data,
    output logic              out_last
);
    import b64sc_pkg::*;

    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [7:0] byte_reg, byte_next;
    logic       has_reg, has_next;
    logic       last_reg, last_next;
    logic       advance, final_res;
    logic [5:0] sextet;
    logic [7:0] dec_byte;
    logic [2:0] pad_sum;

    assign advance   = cmd_valid && (!valid_reg || pop);
    assign final_res = ({1'b0, idx_reg} == cmd.nres - 3'd1);
    assign cmd_pop   = advance && final_res;
    assign pad_sum   = {1'b0, idx_reg} + {1'b0, cmd.npad};

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = cmd.group[23:18];
            2'd1:    sextet = cmd.group[17:12];
            2'd2:    sextet = cmd.group[11:6];
            default: sextet = cmd.group[5:0];
        endcase
        case (idx_reg)
            2'd0:    dec_byte = cmd.group[23:16];
            2'd1:    dec_byte = cmd.group[15:8];
            default: dec_byte = cmd.group[7:0];
        endcase
        has_next  = 1'b1;
        last_next = cmd.last && final_res;
        if (cmd.marker)
        begin
            byte_next = 8'h00;
            has_next  = 1'b0;
        end
        else if (cmd.dec)
        begin
            byte_next = dec_byte;
        end
        else if (pad_sum[2])
        begin
            byte_next = PAD_CHAR;
        end
        else
        begin
            byte_next = to_char(sextet);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= final_res ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= byte_next;
            has_reg  <= has_next;
            last_reg <= last_next;
        end
    end

    assign empty    = !valid_reg;
    assign out_byte = byte_reg;
    assign has_data = has_reg;
    assign out_last = last_reg;

endmodule

/* hdl/base64_stream_codec.sv */
// Base64 stream codec. Write cfg_wdata 0 to encode bytes or 1 to decode characters; a
// write also drops any partial message, so change mode only while the codec is idle.
// The front end groups input items and hands finished groups to a two-entry queue; the
// back end emits one result per cycle from that queue through a registered output while
// the consumer keeps popping. When encoding, the output side sets the sustained rate (four
// characters per three bytes); when decoding, the input side sets it (four characters in
// per three bytes out). The last item of a group reaches its first result through the
// queue entry and then the output register.
module base64_stream_codec (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       has_data,
    output logic       out_last
);
    import b64sc_pkg::*;

    cmd_t front_cmd, head_cmd;
    logic cmd_push, head_valid, cmd_pop;

    b64sc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (push && !full),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    b64sc_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (front_cmd),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (cmd_pop)
    );

    b64sc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .has_data  (has_data),
        .out_last  (out_last)
    );

endmodule

/* hdl/b64sc_checker.sv */
`include "base64_stream_codec_macros.svh"

module b64sc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       has_data,
    input logic       out_last
);

    // An empty end marker always closes its message and carries a zero byte.
    `B64SC_ASSERT_SAME(marker_is_last, clk, rst_n, !empty && !has_data, out_last, "marker without last")
    `B64SC_ASSERT_SAME(marker_is_zero, clk, rst_n, !empty && !has_data, out_byte == 8'h00, "marker byte not zero")

    // A result that is not taken stays in place.
    `B64SC_ASSERT_NEXT(result_holds, clk, rst_n, !empty && !pop,
        !empty && $stable(out_byte) && $stable(has_data) && $stable(out_last),
        "result changed while stalled")

endmodule

bind base64_stream_codec b64sc_checker u_b64sc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .has_data  (has_data),
    .out_last  (out_last)
);

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64sc_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } codec_item_t;

    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } codec_result_t;

    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 70;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       push = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       has_data;
    logic       out_last;

    codec_item_t   pending_items[$];
    codec_result_t expected_results[$];

    string b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic        codec_mode = MODE_ENCODE;
    logic [23:0] group_bits = 24'h0;
    int          group_fill = 0;
    logic        decode_halted = 1'b0;

    logic steady = 1'b0;
    logic pressure_phase = 1'b0;
    logic pressure_done = 1'b0;
    int   hold_left = 0;
    int   fail_count = 0;
    int   items_accepted = 0;
    int   results_checked = 0;
    int   markers_seen = 0;

    base64_stream_codec dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .has_data  (has_data),
        .out_last  (out_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return b64_alphabet[v];
    endfunction

    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
        begin
            if (b64_alphabet[i] == c)
            begin
                return 7'(i);
            end
        end
        return 7'd64;
    endfunction

    function automatic void expect_result(input logic [7:0] data, input logic has_byte,
                                          input logic last, inout int produced);
        codec_result_t r;
        r.data = data;
        r.has_byte = has_byte;
        r.last = last;
        expected_results.push_back(r);
        produced++;
    endfunction

    function automatic void predict_codec(input logic [7:0] b, input logic last);
        int          produced;
        logic [23:0] g;
        logic [6:0]  v;
        produced = 0;
        if (codec_mode == MODE_ENCODE)
        begin
            group_bits = {group_bits[15:0], b};
            if (group_fill == 2)
            begin
                expect_result(sextet_char(group_bits[23:18]), 1'b1, 1'b0, produced);
                expect_result(sextet_char(group_bits[17:12]), 1'b1, 1'b0, produced);
                expect_result(sextet_char(group_bits[11:6]), 1'b1, 1'b0, produced);
                expect_result(sextet_char(group_bits[5:0]), 1'b1, last, produced);
                group_bits = 24'h0;
                group_fill = 0;
            end
            else if (last)
            begin
                g = group_bits << (8 * (2 - group_fill));
                expect_result(sextet_char(g[23:18]), 1'b1, 1'b0, produced);
                expect_result(sextet_char(g[17:12]), 1'b1, 1'b0, produced);
                expect_result(group_fill == 1 ? sextet_char(g[11:6]) : PAD_CHAR,
                              1'b1, 1'b0, produced);
                expect_result(PAD_CHAR, 1'b1, 1'b1, produced);
            end
            else
            begin
                group_fill++;
            end
        end
        else
        begin
            if (!decode_halted)
            begin
                v = char_sextet(b);
                if (v[6])
                begin
                    decode_halted = 1'b1;
                end
                else
                begin
                    group_bits = {group_bits[17:0], v[5:0]};
                    if (group_fill == 3)
                    begin
                        expect_result(group_bits[23:16], 1'b1, 1'b0, produced);
                        expect_result(group_bits[15:8], 1'b1, 1'b0, produced);
                        expect_result(group_bits[7:0], 1'b1, last, produced);
                        group_bits = 24'h0;
                        group_fill = 0;
                    end
                    else
                    begin
                        group_fill++;
                    end
                end
            end
            if (last && group_fill >= 2)
            begin
                g = group_bits << (6 * (4 - group_fill));
                expect_result(g[23:16], 1'b1, group_fill == 2, produced);
                if (group_fill == 3)
                begin
                    expect_result(g[15:8], 1'b1, 1'b1, produced);
                end
            end
        end
        if (last)
        begin
            if (produced == 0)
            begin
                expect_result(8'h00, 1'b0, 1'b1, produced);
            end
            group_bits = 24'h0;
            group_fill = 0;
            decode_halted = 1'b0;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            predict_codec(pending_items[0].data, pending_items[0].last);
            void'(pending_items.pop_front());
            items_accepted++;
        end
        if (rst_n && pending_items.size() > 0 && (steady || $urandom_range(99) >= 15))
        begin
            push <= 1'b1;
            in_byte <= pending_items[0].data;
            in_last <= pending_items[0].last;
        end
        else
        begin
            push <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        codec_result_t want;
        if (rst_n && pop && !empty)
        begin
            results_checked++;
            if (!has_data)
            begin
                markers_seen++;
            end
            if (expected_results.size() == 0)
            begin
                $error("Result transaction with no expectation: out_byte %0h", out_byte);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %0h, actual %0h", want.data, out_byte);
                    fail_count++;
                end
                if (has_data !== want.has_byte)
                begin
                    $error("has_data: expected %0b, actual %0b", want.has_byte, has_data);
                    fail_count++;
                end
                if (out_last !== want.last)
                begin
                    $error("out_last: expected %0b, actual %0b", want.last, out_last);
                    fail_count++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (pressure_phase && !pressure_done)
        begin
            hold_left = LONG_HOLD_CYCLES;
            pressure_done = 1'b1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= rst_n && (steady || $urandom_range(99) >= 15);
        end
    end

    task automatic add_item(input logic [7:0] data, input logic last);
        codec_item_t it;
        it.data = data;
        it.last = last;
        pending_items.push_back(it);
    endtask

    task automatic add_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++)
        begin
            add_item(s[i], last && (i == s.len() - 1));
        end
    endtask

    task automatic add_message(ref logic [7:0] msg[$], inout int count);
        for (int i = 0; i < msg.size(); i++)
        begin
            add_item(msg[i], i == msg.size() - 1);
        end
        count += msg.size();
    endtask

    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() != 0 || push || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        codec_mode = m;
        group_bits = 24'h0;
        group_fill = 0;
        decode_halted = 1'b0;
    endtask

    task automatic encode_phase(inout int count);
        logic [7:0] msg[$];
        int         len;
        msg = {};
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
        for (int i = 0; i < len; i++)
        begin
            msg.push_back(8'($urandom_range(255)));
        end
        add_message(msg, count);
    endtask

    task automatic decode_phase(inout int count);
        logic [7:0] msg[$];
        int         kind;
        int         k;
        msg = {};
        kind = $urandom_range(9);
        if (kind <= 7)
        begin
            k = $urandom_range(2, 12);
            if (k % 4 == 1)
            begin
                k++;
            end
            for (int i = 0; i < k; i++)
            begin
                msg.push_back(sextet_char(6'($urandom_range(63))));
            end
            while (msg.size() % 4 != 0)
            begin
                msg.push_back(PAD_CHAR);
            end
            if (kind == 7)
            begin
                msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
            end
        end
        else
        begin
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++)
            begin
                msg.push_back(8'($urandom_range(255)));
            end
        end
        add_message(msg, count);
    endtask

    initial
    begin
        logic phase_mode;
        int   count;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_mode(MODE_ENCODE);
        add_item(8'hFB, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'hBF, 1'b0);
        add_item(8'h00, 1'b1);
        add_item(8'hFF, 1'b0);
        add_item(8'h01, 1'b1);
        add_item(8'h41, 1'b0);
        drain();

        write_mode(MODE_DECODE);
        add_text("TWFu", 1'b1);
        add_text("QUI=", 1'b1);
        add_text("A", 1'b1);
        add_text("=", 1'b1);
        add_text("/+9z@Q", 1'b1);
        add_text("Zm", 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            phase_mode = (ph == 1 || ph == 3 || ph == 4) ? MODE_DECODE : MODE_ENCODE;
            write_mode(phase_mode);
            pressure_phase = (ph == 0);
            steady = (ph == 3);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if (phase_mode == MODE_ENCODE)
                begin
                    encode_phase(count);
                end
                else
                begin
                    decode_phase(count);
                end
            end
            if ($urandom_range(1) == 1)
            begin
                for (int i = 0; i < $urandom_range(1, 3); i++)
                begin
                    add_item(phase_mode == MODE_ENCODE ? 8'($urandom_range(255)) :
                             sextet_char(6'($urandom_range(63))), 1'b0);
                end
            end
            drain();
            pressure_phase = 1'b0;
            steady = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d input transactions and %0d result transactions (%0d end markers)",
                 items_accepted, results_checked, markers_seen);
        $display("in both modes, with mode changes mid-message and a %0d-cycle output stall.",
                 LONG_HOLD_CYCLES);
        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
